FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the fmbq_checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, skipped while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/core/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// types, sizes and codes shared by the front/middle/back queue
// ----------------------------------------------------------------------------
package fmbq_pkg;

   // storage shape
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // request and response field widths
   localparam int OPERATION_WIDTH = 3;
   localparam int VALUE_WIDTH     = 32;
   localparam int STATUS_WIDTH    = 2;
   localparam int COUNT_WIDTH     = 5;

   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_PUSH_FRONT  = 3'd0,
      OP_PUSH_MIDDLE = 3'd1,
      OP_PUSH_BACK   = 3'd2,
      OP_POP_FRONT   = 3'd3,
      OP_POP_MIDDLE  = 3'd4,
      OP_POP_BACK    = 3'd5
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [OPERATION_WIDTH-1:0]    operation;
      logic signed [VALUE_WIDTH-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] popped_value;
      logic [STATUS_WIDTH-1:0]       status;
      logic [COUNT_WIDTH-1:0]        entry_count;
   } rsp_type;

endpackage

FILE: rtl/core/fmbq_req_if.sv
// ----------------------------------------------------------------------------
// fmbq_req_if
// request channel: operation code and word to push
// ----------------------------------------------------------------------------
interface fmbq_req_if import fmbq_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [OPERATION_WIDTH-1:0]    operation;
   logic signed [VALUE_WIDTH-1:0] push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

FILE: rtl/core/fmbq_rsp_if.sv
// ----------------------------------------------------------------------------
// fmbq_rsp_if
// response channel: popped word, status and count after the operation
// ----------------------------------------------------------------------------
interface fmbq_rsp_if import fmbq_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] popped_value;
   logic [STATUS_WIDTH-1:0]       status;
   logic [COUNT_WIDTH-1:0]        entry_count;

   modport source  (output valid, output popped_value, output status, output entry_count,
                    input ready);
   modport sink    (input valid, input popped_value, input status, input entry_count,
                    output ready);
   modport monitor (input valid, input ready, input popped_value, input status,
                    input entry_count);
endinterface

FILE: rtl/core/fmbq_input_stage.sv
// ----------------------------------------------------------------------------
// fmbq_input_stage
// request register in front of the store logic
// ----------------------------------------------------------------------------
module fmbq_input_stage import fmbq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   fmbq_req_if.sink req_bus,
   input  logic    out_ready,
   output logic    advance,
   output req_type req_q
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    take;

   assign advance       = valid_ff && out_ready;
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;
   assign req_q         = req_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.operation  <= req_bus.operation;
         req_ff.push_value <= req_bus.push_value;
      end
   end

endmodule

FILE: rtl/core/fmbq_store.sv
// ----------------------------------------------------------------------------
// fmbq_store
// word row and count, with the combinational insert/remove shift
// ----------------------------------------------------------------------------
module fmbq_store import fmbq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req_q,
   output rsp_type result
);

   logic [DATA_WIDTH-1:0] words_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] words_in [CAPACITY];
   logic [DATA_WIDTH-1:0] up_word  [CAPACITY];
   logic [DATA_WIDTH-1:0] dn_word  [CAPACITY];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   // neighbours for the shift, fixed per entry
   for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
      if (g == 0) begin : g_first
         assign up_word[g] = words_ff[g];
      end else begin : g_rest
         assign up_word[g] = words_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign dn_word[g] = words_ff[g];
      end else begin : g_inner
         assign dn_word[g] = words_ff[g+1];
      end
   end

   always_comb begin
      logic [CNT_W-1:0]                  pos;
      logic [DATA_WIDTH+VALUE_WIDTH-1:0] push_ext;
      logic [DATA_WIDTH-1:0]             push_word;
      logic [DATA_WIDTH-1:0]             pop_word;
      logic [DATA_WIDTH+VALUE_WIDTH-1:0] pop_ext;
      logic [CNT_W+COUNT_WIDTH-1:0]      cnt_ext;
      logic                              is_push;
      logic                              is_pop;
      status_type                        status;

      words_in  = words_ff;
      count_in  = count_ff;
      pos       = '0;
      is_push   = 1'b0;
      is_pop    = 1'b0;
      status    = STATUS_DONE;
      push_ext  = {{DATA_WIDTH{1'b0}}, req_q.push_value};
      push_word = push_ext[DATA_WIDTH-1:0];

      unique case (op_type'(req_q.operation))
         OP_PUSH_FRONT: begin
            is_push = 1'b1;
            pos     = '0;
         end
         OP_PUSH_MIDDLE: begin
            is_push = 1'b1;
            pos     = count_ff >> 1;
         end
         OP_PUSH_BACK: begin
            is_push = 1'b1;
            pos     = count_ff;
         end
         OP_POP_FRONT: begin
            is_pop = 1'b1;
            pos    = '0;
         end
         OP_POP_MIDDLE: begin
            is_pop = 1'b1;
            pos    = (count_ff - CNT_W'(1)) >> 1;
         end
         OP_POP_BACK: begin
            is_pop = 1'b1;
            pos    = count_ff - CNT_W'(1);
         end
         default: begin
            is_push = 1'b0;
            is_pop  = 1'b0;
         end
      endcase

      pop_word = words_ff[pos[IDX_W-1:0]];
      pop_ext  = '0;

      if (is_push) begin
         if (count_ff == CNT_W'(CAPACITY)) begin
            status = STATUS_FULL;
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CNT_W'(i) == pos) begin
                  words_in[i] = push_word;
               end else if (CNT_W'(i) > pos) begin
                  words_in[i] = up_word[i];
               end
            end
            count_in = count_ff + CNT_W'(1);
         end
      end else if (is_pop) begin
         if (count_ff == '0) begin
            status = STATUS_EMPTY;
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CNT_W'(i) >= pos) begin
                  words_in[i] = dn_word[i];
               end
            end
            count_in = count_ff - CNT_W'(1);
            pop_ext  = {{VALUE_WIDTH{1'b0}}, pop_word};
         end
      end

      cnt_ext             = {{COUNT_WIDTH{1'b0}}, count_in};
      result.popped_value = pop_ext[VALUE_WIDTH-1:0];
      result.status       = status;
      result.entry_count  = cnt_ext[COUNT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

   // word row, undefined until written
   always_ff @(posedge clock) begin
      if (advance) begin
         words_ff <= words_in;
      end
   end

endmodule

FILE: rtl/core/fmbq_output_stage.sv
// ----------------------------------------------------------------------------
// fmbq_output_stage
// response register towards the sink
// ----------------------------------------------------------------------------
module fmbq_output_stage import fmbq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  rsp_type   result,
   output logic      out_ready,
   fmbq_rsp_if.source rsp_bus
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign out_ready            = !valid_ff || rsp_bus.ready;
   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.popped_value = rsp_ff.popped_value;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.entry_count  = rsp_ff.entry_count;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

endmodule

FILE: rtl/core/front_middle_back_queue_top.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_top
// bounded ordered word store with push/pop at front, middle and back
// ----------------------------------------------------------------------------
// each request is one operation: push front, middle (at count/2) or back, or
// pop front, middle (at (count-1)/2) or back. every request gives exactly one
// response with the popped word (zero unless a pop succeeds), a status (done,
// pop on empty, push on full dropped) and the count afterwards. unused codes
// do nothing and report the current count. from acceptance a request passes
// the request register, then the response register, and one request is
// accepted every cycle while responses are taken; the rate rests on the word
// row, whose entries from the chosen position onward shift by one place
// together. the row needs no clearing after reset, only the count is
// cleared, so requests are taken from the first cycle after reset
// ----------------------------------------------------------------------------
module front_middle_back_queue_top import fmbq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fmbq_req_if.sink   req_bus,
   fmbq_rsp_if.source rsp_bus
);

   logic    advance;     // request register moves into the store and response
   logic    out_ready;   // response register can take a new result
   req_type req_q;
   rsp_type result;

   // request register
   fmbq_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_ready (out_ready),
      .advance   (advance),
      .req_q     (req_q)
   );

   // word row, count and the operation itself
   fmbq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req_q   (req_q),
      .result  (result)
   );

   // response register
   fmbq_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_ready (out_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: rtl/core/fmbq_checker.sv
// ----------------------------------------------------------------------------
// fmbq_checker
// port-level checks on the response channel of the queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmbq_checker import fmbq_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_popped_value,
   input logic [STATUS_WIDTH-1:0]       rsp_status,
   input logic [COUNT_WIDTH-1:0]        rsp_entry_count
);

   // nothing comes out straight after reset
   `ASSERT_NEXT(a_quiet_after_reset, clock, 1'b0, reset, !rsp_valid)

   // an empty pop leaves an empty store and no word
   `ASSERT_IMPLIES(a_empty_pop, clock, reset,
      rsp_valid && rsp_status == STATUS_EMPTY,
      rsp_entry_count == '0 && rsp_popped_value == '0)

   // a dropped push only happens at capacity
   `ASSERT_IMPLIES(a_full_push, clock, reset,
      rsp_valid && rsp_status == STATUS_FULL,
      rsp_entry_count == COUNT_WIDTH'(CAPACITY) && rsp_popped_value == '0)

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_popped_value) && $stable(rsp_status)
      && $stable(rsp_entry_count))

endmodule

bind front_middle_back_queue_top fmbq_checker u_fmbq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_popped_value (rsp_bus.popped_value),
   .rsp_status       (rsp_bus.status),
   .rsp_entry_count  (rsp_bus.entry_count)
);
